>>> sv/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types and constants of the scan segment densifier: register indexes,
// register reset values and the fixed widths of the length datapath.
// ----------------------------------------------------------------------------
package ssd_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t REG_SPACING = 2'd0;
  localparam cfg_idx_t REG_MAX_GAP = 2'd1;

  localparam int SP_W  = 10;
  localparam int GAP_W = 13;
  typedef logic [SP_W-1:0]  spacing_t;
  typedef logic [GAP_W-1:0] gap_t;

  localparam spacing_t SPACING_RST = 10'd50;
  localparam gap_t     MAX_GAP_RST = 13'd1000;

  // squared length of a segment that passes the gap test: 2 * 8191^2 < 2^27
  localparam int L2_W = 27;
  typedef logic [L2_W-1:0] l2_t;

  // shared compare-subtract unit width
  localparam int CMP_W = L2_W + 1;
  typedef logic [CMP_W-1:0] cmp_t;

  // root and restoring division words are both 14 bits
  localparam int DIV_W = GAP_W + 1;
  typedef logic [DIV_W-1:0] div_t;

  localparam int  SQRT_STEPS = L2_W / 2 + 1;
  localparam l2_t SQRT_BIT0  = l2_t'(1) << (L2_W - 1);

  localparam int STEP_CNT_W = 4;
  typedef logic [STEP_CNT_W-1:0] step_cnt_t;

  localparam step_cnt_t SQRT_LAST = step_cnt_t'(SQRT_STEPS - 1);
  localparam step_cnt_t DIV_LAST  = step_cnt_t'(DIV_W - 1);

endpackage

>>> sv/ssd_cfg_if.sv
// ----------------------------------------------------------------------------
// ssd_cfg_if
// Register write channel: valid, ready, register index and write data.
// ----------------------------------------------------------------------------
interface ssd_cfg_if ();
  import ssd_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/ssd_in_if.sv
// ----------------------------------------------------------------------------
// ssd_in_if
// Scan point channel: one word is one scan point with its flags.
// ----------------------------------------------------------------------------
interface ssd_in_if #(
  parameter int COORD_BITS = 20
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         point_ok;
  logic                         scan_start;

  modport source (output valid, point_x, point_y, point_ok, scan_start, input ready);
  modport sink   (input valid, point_x, point_y, point_ok, scan_start, output ready);
endinterface

>>> sv/ssd_out_if.sv
// ----------------------------------------------------------------------------
// ssd_out_if
// Densified point channel: one word is one emitted point.
// ----------------------------------------------------------------------------
interface ssd_out_if #(
  parameter int COORD_BITS = 20
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         run_last;

  modport source (output valid, out_x, out_y, run_last, input ready);
  modport sink   (input valid, out_x, out_y, run_last, output ready);
endinterface

>>> sv/scan_segment_densifier.sv
// ----------------------------------------------------------------------------
// scan_segment_densifier
// Pairs each scan point with the previous one and emits evenly spaced points
// along the segment, excluding its end point.
// ----------------------------------------------------------------------------
// One input word is taken while the block is idle. A point that does not pair
// (no previous point, scan start, or either point invalid) emits nothing. A
// pair whose segment is longer than max_gap_mm emits p1 alone, whether the
// axis test or the squared length test fails. A pair that is interpolated
// occupies the block, and no next word is taken, until the last of its n
// emitted points (1 to MAX_STEPS) is registered: one compare-subtract unit
// runs the 14-step square root and three 14-step restoring divisions (length
// by spacing, then 2|dx| and 2|dy| by 2n), one bit per cycle, after which
// one point leaves per cycle while the sink is ready. The output word register
// lets a new scan point be taken while the last point of the previous one
// still waits. Register writes are always accepted.
// ----------------------------------------------------------------------------
module scan_segment_densifier #(
  parameter int MAX_STEPS  = 64,
  parameter int COORD_BITS = 20
) (
  input  logic       clk,
  input  logic       rst_n,
  ssd_cfg_if.sink    cfg_ch,
  ssd_in_if.sink     in_ch,
  ssd_out_if.source  out_ch
);
  import ssd_pkg::*;

  localparam int DW   = COORD_BITS + 1;
  localparam int N_W  = $clog2(MAX_STEPS + 1);
  localparam int D2_W = N_W + 1;
  localparam int R_W  = N_W + 2;
  localparam int RM_W = (SP_W > D2_W) ? SP_W : D2_W;
  localparam int EW   = (COORD_BITS > DIV_W) ? COORD_BITS : DIV_W;
  localparam logic [N_W-1:0] N_MAX = N_W'(MAX_STEPS);
  localparam logic [N_W-1:0] N_ONE = N_W'(1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ABS   = 4'd1;
  localparam logic [3:0] S_MUL_A = 4'd2;
  localparam logic [3:0] S_MUL_B = 4'd3;
  localparam logic [3:0] S_MUL_G = 4'd4;
  localparam logic [3:0] S_GAP   = 4'd5;
  localparam logic [3:0] S_SQRT  = 4'd6;
  localparam logic [3:0] S_NDIV  = 4'd7;
  localparam logic [3:0] S_XDIV  = 4'd8;
  localparam logic [3:0] S_YDIV  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  logic [3:0] state_r;

  spacing_t spacing_r;
  gap_t     max_gap_r;

  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic                         prev_ok_r, have_prev_r;
  logic signed [COORD_BITS-1:0] x1_r, y1_r;
  logic signed [DW-1:0]         dx_r, dy_r;
  gap_t                         adx_r, ady_r;
  logic                         negx_r, negy_r;

  l2_t       l2_r, g2_r, v_r, bit_r, root_r;
  step_cnt_t cnt_r;
  div_t      dq_r;
  logic [RM_W-1:0] rem_r;

  logic [N_W-1:0]  n_r, k_r;
  div_t            qx_r, qy_r, bqx_r, bqy_r;
  logic [D2_W-1:0] rx_r, ry_r, brx_r, bry_r;

  logic                         out_valid_r;
  logic signed [COORD_BITS-1:0] out_x_r, out_y_r;
  logic                         run_last_r;

  // ready and accept
  logic in_acc, pair, slot_free;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign pair         = have_prev_r && !in_ch.scan_start && prev_ok_r && in_ch.point_ok;
  assign cfg_ch.ready = 1'b1;
  assign slot_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_x    = out_x_r;
  assign out_ch.out_y    = out_y_r;
  assign out_ch.run_last = run_last_r;

  // absolute differences and axis gap test
  logic [DW-1:0] adx_full, ady_full;
  logic          far_axis;
  assign adx_full = dx_r[DW-1] ? DW'(-dx_r) : DW'(dx_r);
  assign ady_full = dy_r[DW-1] ? DW'(-dy_r) : DW'(dy_r);
  assign far_axis = (adx_full > DW'(max_gap_r)) || (ady_full > DW'(max_gap_r));

  // squaring multiplier
  gap_t                 mul_op;
  logic [2*GAP_W-1:0]   mul_p;
  always_comb begin
    unique case (state_r)
      S_MUL_A: mul_op = adx_r;
      S_MUL_B: mul_op = ady_r;
      default: mul_op = max_gap_r;
    endcase
  end
  assign mul_p = mul_op * mul_op;

  // shared compare-subtract unit
  spacing_t        sp_eff;
  logic [D2_W-1:0] two_n;
  cmp_t            cu_a, cu_b, cu_diff;
  logic            cu_ge;
  assign sp_eff = (spacing_r == '0) ? SP_W'(1) : spacing_r;
  assign two_n  = {n_r, 1'b0};

  always_comb begin
    unique case (state_r)
      S_SQRT: begin
        cu_a = CMP_W'(v_r);
        cu_b = CMP_W'(root_r) + CMP_W'(bit_r);
      end
      S_NDIV: begin
        cu_a = CMP_W'({rem_r, dq_r[DIV_W-1]});
        cu_b = CMP_W'(sp_eff);
      end
      S_XDIV, S_YDIV: begin
        cu_a = CMP_W'({rem_r, dq_r[DIV_W-1]});
        cu_b = CMP_W'(two_n);
      end
      default: begin
        cu_a = '0;
        cu_b = '0;
      end
    endcase
  end
  assign cu_ge   = (cu_a >= cu_b);
  assign cu_diff = cu_a - cu_b;

  l2_t             root_nxt, v_nxt;
  div_t            dq_nxt;
  logic [RM_W-1:0] rem_nxt;
  assign root_nxt = cu_ge ? ((root_r >> 1) + bit_r) : (root_r >> 1);
  assign v_nxt    = cu_ge ? cu_diff[L2_W-1:0] : v_r;
  assign dq_nxt   = {dq_r[DIV_W-2:0], cu_ge};
  assign rem_nxt  = cu_ge ? cu_diff[RM_W-1:0] : cu_a[RM_W-1:0];

  // step count from length / spacing
  logic [N_W-1:0] n_nxt;
  always_comb begin
    priority if (dq_nxt == '0) begin
      n_nxt = N_ONE;
    end else if (dq_nxt > DIV_W'(MAX_STEPS)) begin
      n_nxt = N_MAX;
    end else begin
      n_nxt = dq_nxt[N_W-1:0];
    end
  end

  // emit step: running quotient and remainder of (2k|d| + n) / 2n
  logic [R_W-1:0]  sum_rx, sum_ry;
  logic            cx, cy;
  logic [D2_W-1:0] rx_nxt, ry_nxt;
  div_t            qx_nxt, qy_nxt;
  logic [EW-1:0]   ox, oy;
  logic            last_k;
  assign sum_rx = R_W'(rx_r) + R_W'(brx_r);
  assign sum_ry = R_W'(ry_r) + R_W'(bry_r);
  assign cx     = (sum_rx >= R_W'(two_n));
  assign cy     = (sum_ry >= R_W'(two_n));
  assign rx_nxt = cx ? D2_W'(sum_rx - R_W'(two_n)) : D2_W'(sum_rx);
  assign ry_nxt = cy ? D2_W'(sum_ry - R_W'(two_n)) : D2_W'(sum_ry);
  assign qx_nxt = qx_r + bqx_r + DIV_W'(cx);
  assign qy_nxt = qy_r + bqy_r + DIV_W'(cy);
  assign ox     = EW'(x1_r) + (negx_r ? -EW'(qx_r) : EW'(qx_r));
  assign oy     = EW'(y1_r) + (negy_r ? -EW'(qy_r) : EW'(qy_r));
  assign last_k = (k_r == (n_r - N_ONE));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= SPACING_RST;
      max_gap_r <= MAX_GAP_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.index == REG_SPACING) begin
        spacing_r <= cfg_ch.data[SP_W-1:0];
      end
      if (cfg_ch.index == REG_MAX_GAP) begin
        max_gap_r <= cfg_ch.data[GAP_W-1:0];
      end
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_ok_r   <= 1'b0;
      have_prev_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            prev_x_r    <= in_ch.point_x;
            prev_y_r    <= in_ch.point_y;
            prev_ok_r   <= in_ch.point_ok;
            have_prev_r <= 1'b1;
            x1_r        <= prev_x_r;
            y1_r        <= prev_y_r;
            dx_r        <= DW'(in_ch.point_x) - DW'(prev_x_r);
            dy_r        <= DW'(in_ch.point_y) - DW'(prev_y_r);
            if (pair) begin
              state_r <= S_ABS;
            end
          end
        end
        S_ABS: begin
          adx_r  <= adx_full[GAP_W-1:0];
          ady_r  <= ady_full[GAP_W-1:0];
          negx_r <= dx_r[DW-1];
          negy_r <= dy_r[DW-1];
          if (far_axis) begin
            n_r     <= N_ONE;
            bqx_r   <= '0;
            bqy_r   <= '0;
            brx_r   <= '0;
            bry_r   <= '0;
            qx_r    <= '0;
            qy_r    <= '0;
            rx_r    <= D2_W'(1);
            ry_r    <= D2_W'(1);
            k_r     <= '0;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_MUL_A;
          end
        end
        S_MUL_A: begin
          l2_r    <= L2_W'(mul_p);
          state_r <= S_MUL_B;
        end
        S_MUL_B: begin
          l2_r    <= l2_r + L2_W'(mul_p);
          state_r <= S_MUL_G;
        end
        S_MUL_G: begin
          g2_r    <= L2_W'(mul_p);
          state_r <= S_GAP;
        end
        S_GAP: begin
          if (l2_r > g2_r) begin
            n_r     <= N_ONE;
            bqx_r   <= '0;
            bqy_r   <= '0;
            brx_r   <= '0;
            bry_r   <= '0;
            qx_r    <= '0;
            qy_r    <= '0;
            rx_r    <= D2_W'(1);
            ry_r    <= D2_W'(1);
            k_r     <= '0;
            state_r <= S_EMIT;
          end else begin
            v_r     <= l2_r;
            root_r  <= '0;
            bit_r   <= SQRT_BIT0;
            cnt_r   <= '0;
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          v_r    <= v_nxt;
          root_r <= root_nxt;
          bit_r  <= bit_r >> 2;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == SQRT_LAST) begin
            dq_r    <= root_nxt[DIV_W-1:0];
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_NDIV;
          end
        end
        S_NDIV: begin
          dq_r  <= dq_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_LAST) begin
            n_r     <= n_nxt;
            dq_r    <= {adx_r, 1'b0};
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_XDIV;
          end
        end
        S_XDIV: begin
          dq_r  <= dq_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_LAST) begin
            bqx_r   <= dq_nxt;
            brx_r   <= rem_nxt[D2_W-1:0];
            dq_r    <= {ady_r, 1'b0};
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= S_YDIV;
          end
        end
        S_YDIV: begin
          dq_r  <= dq_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == DIV_LAST) begin
            bqy_r   <= dq_nxt;
            bry_r   <= rem_nxt[D2_W-1:0];
            qx_r    <= '0;
            qy_r    <= '0;
            rx_r    <= D2_W'(n_r);
            ry_r    <= D2_W'(n_r);
            k_r     <= '0;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_x_r     <= ox[COORD_BITS-1:0];
            out_y_r     <= oy[COORD_BITS-1:0];
            run_last_r  <= last_k;
            qx_r        <= qx_nxt;
            qy_r        <= qy_nxt;
            rx_r        <= rx_nxt;
            ry_r        <= ry_nxt;
            k_r         <= k_r + 1'b1;
            if (last_k) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> sv/ssd_checker.sv
// ----------------------------------------------------------------------------
// ssd_port_checker
// Port-level checks of the scan segment densifier, bound to the top level.
// ----------------------------------------------------------------------------
module ssd_port_checker #(
  parameter int COORD_BITS = 20
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_point_ok,
  input logic                         in_scan_start,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [COORD_BITS-1:0] out_x,
  input logic signed [COORD_BITS-1:0] out_y,
  input logic                         out_run_last
);

  // a stalled output word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // a stalled output word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_x) && $stable(out_y) && $stable(out_run_last))
    else $error("output payload changed while stalled");

  // a run that is not finished keeps the input closed
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> !in_ready)
    else $error("input opened in the middle of a run");

  // a point that cannot pair leaves the block idle
  a_no_pair_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (!in_point_ok || in_scan_start) |=> in_ready)
    else $error("unpaired point started work");

endmodule

bind scan_segment_densifier ssd_port_checker #(
  .COORD_BITS(COORD_BITS)
) u_ssd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_point_ok   (in_ch.point_ok),
  .in_scan_start (in_ch.scan_start),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_x         (out_ch.out_x),
  .out_y         (out_ch.out_y),
  .out_run_last  (out_ch.run_last)
);
